### src/r2bf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package r2bf_pkg;

  localparam int DATA_W        = 16;
  localparam int LEN_W         = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int MAX_PAIRS_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SPAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWIDDLE_RE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TWIDDLE_IM = 2'd3;

  localparam logic signed [DATA_W-1:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [DATA_W-1:0] Q14_ZERO = 16'sd0;
  localparam logic signed [DATA_W-1:0] SAT_MAX  = 16'sd32767;
  localparam logic signed [DATA_W-1:0] SAT_MIN  = -16'sd32768;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  // add half an LSB, floor shift by 14, saturate
  function automatic logic signed [DATA_W-1:0] round_q14(input logic signed [32:0] v);
    logic signed [33:0] a;
    logic signed [19:0] q;
    a = 34'(v) + 34'sd8192;
    q = a[33:14];
    if (q > 20'sd32767) begin
      round_q14 = SAT_MAX;
    end else if (q < -20'sd32768) begin
      round_q14 = SAT_MIN;
    end else begin
      round_q14 = q[DATA_W-1:0];
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat17(input logic signed [DATA_W:0] v);
    if (v > 17'sd32767) begin
      sat17 = SAT_MAX;
    end else if (v < -17'sd32768) begin
      sat17 = SAT_MIN;
    end else begin
      sat17 = v[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### src/r2bf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module r2bf_ctrl #(
  parameter int MAX_PAIRS = r2bf_pkg::MAX_PAIRS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_wr_en,
  input  wire  [r2bf_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire  [r2bf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                  advance,
  output r2bf_pkg::cplx_t                      tw,
  output logic                                 last
);

  localparam int CNT_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int EFF_W = $clog2(MAX_PAIRS + 1);
  localparam int CMP_W = ((EFF_W > r2bf_pkg::LEN_W) ? EFF_W : r2bf_pkg::LEN_W) + 1;

  logic [r2bf_pkg::LEN_W-1:0]         half_span;
  logic [r2bf_pkg::LEN_W-1:0]         pairs_per_block;
  logic signed [r2bf_pkg::DATA_W-1:0] twiddle_re;
  logic signed [r2bf_pkg::DATA_W-1:0] twiddle_im;

  logic [CNT_W-1:0] group_position;
  logic [CNT_W-1:0] block_position;
  r2bf_pkg::cplx_t  running;
  r2bf_pkg::cplx_t  running_next;

  logic [CMP_W-1:0] max_ext;
  logic [CMP_W-1:0] hs_ext;
  logic [CMP_W-1:0] pb_ext;
  logic [CMP_W-1:0] hs_eff;
  logic [CMP_W-1:0] pb_eff;
  logic [CMP_W-1:0] gpos_inc;
  logic [CMP_W-1:0] bpos_inc;
  logic             end_group;

  logic signed [31:0] p_rr;
  logic signed [31:0] p_ii;
  logic signed [31:0] p_ri;
  logic signed [31:0] p_ir;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_span       <= r2bf_pkg::LEN_W'(1);
      pairs_per_block <= r2bf_pkg::LEN_W'(1);
      twiddle_re      <= r2bf_pkg::Q14_ONE;
      twiddle_im      <= r2bf_pkg::Q14_ZERO;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        r2bf_pkg::CFG_HALF_SPAN:  half_span       <= cfg_wdata[r2bf_pkg::LEN_W-1:0];
        r2bf_pkg::CFG_PAIRS:      pairs_per_block <= cfg_wdata[r2bf_pkg::LEN_W-1:0];
        r2bf_pkg::CFG_TWIDDLE_RE: twiddle_re      <= cfg_wdata;
        r2bf_pkg::CFG_TWIDDLE_IM: twiddle_im      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    max_ext = CMP_W'(MAX_PAIRS);
    hs_ext  = CMP_W'(half_span);
    pb_ext  = CMP_W'(pairs_per_block);
    if (hs_ext == '0) begin
      hs_eff = CMP_W'(1);
    end else if (hs_ext > max_ext) begin
      hs_eff = max_ext;
    end else begin
      hs_eff = hs_ext;
    end
    if (pb_ext == '0) begin
      pb_eff = CMP_W'(1);
    end else if (pb_ext > max_ext) begin
      pb_eff = max_ext;
    end else begin
      pb_eff = pb_ext;
    end
    gpos_inc  = CMP_W'(group_position) + CMP_W'(1);
    bpos_inc  = CMP_W'(block_position) + CMP_W'(1);
    end_group = gpos_inc >= hs_eff;
    last      = bpos_inc >= pb_eff;
  end

  // running twiddle times stage twiddle
  assign p_rr = running.re * twiddle_re;
  assign p_ii = running.im * twiddle_im;
  assign p_ri = running.re * twiddle_im;
  assign p_ir = running.im * twiddle_re;

  always_comb begin
    running_next.re = r2bf_pkg::round_q14(33'(p_rr) - 33'(p_ii));
    running_next.im = r2bf_pkg::round_q14(33'(p_ri) + 33'(p_ir));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= '0;
      block_position <= '0;
      running.re     <= r2bf_pkg::Q14_ONE;
      running.im     <= r2bf_pkg::Q14_ZERO;
    end else if (advance) begin
      priority if (last) begin
        group_position <= '0;
        block_position <= '0;
        running.re     <= r2bf_pkg::Q14_ONE;
        running.im     <= r2bf_pkg::Q14_ZERO;
      end else if (end_group) begin
        group_position <= '0;
        block_position <= bpos_inc[CNT_W-1:0];
        running.re     <= r2bf_pkg::Q14_ONE;
        running.im     <= r2bf_pkg::Q14_ZERO;
      end else begin
        group_position <= gpos_inc[CNT_W-1:0];
        block_position <= bpos_inc[CNT_W-1:0];
        running        <= running_next;
      end
    end
  end

  assign tw = running;

  a_group_start_one: assert property (@(posedge clk) disable iff (rst)
    (group_position == '0) |-> (running.re == r2bf_pkg::Q14_ONE && running.im == '0))
    else $error("running twiddle not one at group start");

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    (advance && last) |=> (block_position == '0 && group_position == '0))
    else $error("positions not cleared after block end");

endmodule

`default_nettype wire

### src/r2bf_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module r2bf_pipe (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [4*r2bf_pkg::DATA_W-1:0] s_tdata,
  input  wire  r2bf_pkg::cplx_t         tw,
  input  wire                           last,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [4*r2bf_pkg::DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);

  localparam int W = r2bf_pkg::DATA_W;

  logic en1;
  logic en2;
  logic v1;

  logic signed [W-1:0] in_ur;
  logic signed [W-1:0] in_ui;
  logic signed [W-1:0] in_lr;
  logic signed [W-1:0] in_li;

  logic signed [W-1:0] u_re;
  logic signed [W-1:0] u_im;
  logic signed [31:0]  p_rr;
  logic signed [31:0]  p_ii;
  logic signed [31:0]  p_ri;
  logic signed [31:0]  p_ir;
  logic                last1;

  logic signed [W-1:0] t_re;
  logic signed [W-1:0] t_im;
  logic signed [W-1:0] sum_re;
  logic signed [W-1:0] sum_im;
  logic signed [W-1:0] diff_re;
  logic signed [W-1:0] diff_im;

  assign en2      = !m_tvalid || m_tready;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  assign in_ur = s_tdata[W-1:0];
  assign in_ui = s_tdata[2*W-1:W];
  assign in_lr = s_tdata[3*W-1:2*W];
  assign in_li = s_tdata[4*W-1:3*W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      u_re  <= in_ur;
      u_im  <= in_ui;
      p_rr  <= in_lr * tw.re;
      p_ii  <= in_li * tw.im;
      p_ri  <= in_lr * tw.im;
      p_ir  <= in_li * tw.re;
      last1 <= last;
    end
  end

  always_comb begin
    t_re    = r2bf_pkg::round_q14(33'(p_rr) - 33'(p_ii));
    t_im    = r2bf_pkg::round_q14(33'(p_ri) + 33'(p_ir));
    sum_re  = r2bf_pkg::sat17(17'(u_re) + 17'(t_re));
    sum_im  = r2bf_pkg::sat17(17'(u_im) + 17'(t_im));
    diff_re = r2bf_pkg::sat17(17'(u_re) - 17'(t_re));
    diff_im = r2bf_pkg::sat17(17'(u_im) - 17'(t_im));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en2) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      m_tdata <= {diff_im, diff_re, sum_im, sum_re};
      m_tlast <= last1;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_out_from_stage1: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v1))
    else $error("output word appeared without a stage 1 word");

endmodule

`default_nettype wire

### src/radix2_fft_butterfly_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata: butterfly pair
// m_*       out  tvalid/tready      tdata: sum/diff, tlast: block end
// cfg_*     in   cfg_wr_en          cfg_addr, cfg_wdata
//
// One word per cycle sustained while m_tready stays high; an accepted word
// passes stage 1, then the output register raises m_tvalid (two register
// stages). The running twiddle does one complex multiply and round per
// accepted word. Reset clears the pipeline valids and both position
// counters and loads the running twiddle with one and the config registers
// with their defaults. With m_tready low the output word holds, stage 1
// still fills, and s_tready drops only once both stages are full.

module radix2_fft_butterfly_stage #(
  parameter int MAX_PAIRS = r2bf_pkg::MAX_PAIRS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // upper_re, upper_im, lower_re, lower_im
  input  wire  [4*r2bf_pkg::DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // sum_re, sum_im, diff_re, diff_im
  output logic [4*r2bf_pkg::DATA_W-1:0]    m_tdata,
  output logic                             m_tlast,
  input  wire                              cfg_wr_en,
  input  wire  [r2bf_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire  [r2bf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  r2bf_pkg::cplx_t tw;
  logic            last;
  logic            advance;

  assign advance = s_tvalid && s_tready;

  r2bf_ctrl #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .tw        (tw),
    .last      (last)
  );

  r2bf_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .tw       (tw),
    .last     (last),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
